// ----- rtl/glzw_pkg.sv -----
// Shared types and constants for the GIF LZW code packer.
package glzw_pkg;

	localparam int SYM_BITS   = 8;
	localparam int CODE_BITS  = 12;
	localparam int IDX_BITS   = CODE_BITS + SYM_BITS;
	localparam int DICT_DEPTH = 1 << IDX_BITS;
	localparam int OWNER_DEPTH = 1 << CODE_BITS;
	localparam int WIDTH_BITS = 4;
	localparam int GRP_CODES  = 5;
	localparam int GRP_CNT_BITS = 3;
	localparam int ACC_BITS   = 7 + CODE_BITS;
	localparam int ACC_N_BITS = 5;
	localparam int GRP_DEPTH  = 4;
	localparam int GRP_PTR_BITS = 2;
	localparam int GRP_LVL_BITS = 3;

	localparam logic [CODE_BITS-1:0] CLEAR_CODE = CODE_BITS'(1 << SYM_BITS);
	localparam logic [CODE_BITS-1:0] END_CODE   = CODE_BITS'((1 << SYM_BITS) + 1);
	// last assigned code after a clear, and the first code that can be assigned
	localparam logic [CODE_BITS-1:0] FIRST_FREE = CODE_BITS'((1 << SYM_BITS) + 1);
	localparam logic [CODE_BITS-1:0] FIRST_ASSIGNED = CODE_BITS'((1 << SYM_BITS) + 2);
	localparam logic [CODE_BITS-1:0] DICT_LIMIT = CODE_BITS'((1 << CODE_BITS) - 1);
	localparam logic [WIDTH_BITS-1:0] MIN_WIDTH = WIDTH_BITS'(SYM_BITS + 1);
	localparam logic [WIDTH_BITS-1:0] MAX_WIDTH = WIDTH_BITS'(CODE_BITS);
	// group FIFO level at or below which a new pixel may enter
	localparam logic [GRP_LVL_BITS-1:0] GRP_ROOM_LVL = GRP_LVL_BITS'(GRP_DEPTH - 2);

	typedef struct packed {
		logic [7:0] pixel_index;
		logic       last_pixel;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       end_of_image;
	} byte_out_t;

	// codes produced by one pixel, in emission order
	typedef struct packed {
		logic [GRP_CODES-1:0][CODE_BITS-1:0]  code;
		logic [GRP_CODES-1:0][WIDTH_BITS-1:0] width;
		logic [GRP_CNT_BITS-1:0]              count;
		logic                                 last;
	} code_grp_t;

endpackage

// ----- rtl/gif_lzw_code_packer.sv -----
// Top level of the GIF LZW code packer.
// Input channel pixel_*: one palette index a transaction in raster order,
// last_pixel set on the final pixel of an image. Output channel stream_*:
// LSB-first packed LZW code bytes, end_of_image set on the padded final byte.
// A clear code leads every image; the pending code, a clear code and the
// end code close it.
// Pixels are taken one at a time: the next lookup waits for the trie memory read
// and the dependent owner memory read that decide a hit, and for group FIFO room.
// Pixels that emit codes also occupy the packer, which appends each code and
// sends each byte as its own step; a four-entry code group FIFO absorbs bursts.
// A pixel's codes pass the memory reads and the decision into the FIFO, then the
// packer and its registered output; they wait while earlier codes still drain.
// Reset clears the run state, FIFO and packer; the dictionary needs no clear,
// since each entry is checked against the code owner memory.
// A stalled receiver holds the output register; the FIFO fills and
// pixel_ready drops until bytes drain.
module gif_lzw_code_packer import glzw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pixel_valid,
	output logic      pixel_ready,
	input  pix_in_t   pixel_data,
	output logic      stream_valid,
	input  logic      stream_ready,
	output byte_out_t stream_data
);

	code_grp_t grp;
	logic      grp_valid, grp_room;

	glzw_dict u_dict (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel_data  (pixel_data),
		.grp_room    (grp_room),
		.grp_valid   (grp_valid),
		.grp         (grp)
	);

	glzw_packer u_packer (
		.clk          (clk),
		.arst_n       (arst_n),
		.grp_valid    (grp_valid),
		.grp          (grp),
		.grp_room     (grp_room),
		.stream_valid (stream_valid),
		.stream_ready (stream_ready),
		.stream_data  (stream_data)
	);

endmodule

// ----- rtl/glzw_dict.sv -----
// Dictionary lookup pipeline: trie memory, code owner memory and LZW state.
module glzw_dict import glzw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pixel_valid,
	output logic      pixel_ready,
	input  pix_in_t   pixel_data,
	input  logic      grp_room,
	output logic      grp_valid,
	output code_grp_t grp
);

	logic [CODE_BITS-1:0] dict_mem [DICT_DEPTH];
	logic [IDX_BITS-1:0]  owner_mem [OWNER_DEPTH];
	logic [CODE_BITS-1:0] dict_rd_q;
	logic [IDX_BITS-1:0]  owner_rd_q;

	logic                  valid_s1, last_s1, fwd_s1;
	logic [SYM_BITS-1:0]   pix_s1;
	logic [IDX_BITS-1:0]   idx_s1;
	logic [CODE_BITS-1:0]  fwd_code_s1;
	logic                  valid_s2, last_s2, range_s2;
	logic [SYM_BITS-1:0]   pix_s2;
	logic [IDX_BITS-1:0]   idx_s2;
	logic [CODE_BITS-1:0]  hit_s2;

	logic [CODE_BITS-1:0]  cur_q, nf_q;
	logic                  run_q;
	logic [WIDTH_BITS-1:0] width_q;

	logic                  accept, hit_ok, wr_en;
	logic [CODE_BITS-1:0]  hit_s1, cur_n, nf_n, nf_inc, cur_use, pix_code;
	logic                  run_n;
	logic [WIDTH_BITS-1:0] width_n;
	logic [IDX_BITS-1:0]   rd_idx;
	logic [GRP_CNT_BITS-1:0] n;

	// one pixel in flight between lookup and decision
	assign pixel_ready = !valid_s1 && grp_room;
	assign accept      = pixel_valid && pixel_ready;
	assign cur_use     = valid_s2 ? cur_n : cur_q;
	assign rd_idx      = {cur_use, pixel_data.pixel_index[SYM_BITS-1:0]};
	assign hit_s1      = fwd_s1 ? fwd_code_s1 : dict_rd_q;
	assign nf_inc      = nf_q + 1'b1;
	assign pix_code    = {{(CODE_BITS-SYM_BITS){1'b0}}, pix_s2};
	// entry is live only if this epoch assigned that code to this very index
	assign hit_ok      = range_s2 && (owner_rd_q == idx_s2);

	// trie memory: write from decision, read for the next pixel
	always_ff @(posedge clk) begin
		if (wr_en)
			dict_mem[idx_s2] <= nf_inc;
		if (accept)
			dict_rd_q <= dict_mem[rd_idx];
	end

	// owner memory: index that each assigned code extends
	always_ff @(posedge clk) begin
		if (wr_en)
			owner_mem[nf_inc] <= idx_s2;
		owner_rd_q <= owner_mem[hit_s1];
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= pixel_data.pixel_index[SYM_BITS-1:0];
			last_s1     <= pixel_data.last_pixel;
			idx_s1      <= rd_idx;
			fwd_s1      <= wr_en && (idx_s2 == rd_idx);
			fwd_code_s1 <= nf_inc;
		end
		if (valid_s1) begin
			pix_s2   <= pix_s1;
			last_s2  <= last_s1;
			idx_s2   <= idx_s1;
			hit_s2   <= hit_s1;
			range_s2 <= (hit_s1 >= FIRST_ASSIGNED) && (hit_s1 <= nf_q);
		end
	end

	// decision: next run state and codes to send
	always_comb begin
		grp     = '0;
		n       = '0;
		cur_n   = cur_q;
		run_n   = run_q;
		width_n = width_q;
		nf_n    = nf_q;
		wr_en   = 1'b0;
		if (valid_s2) begin
			if (!run_q) begin
				grp.code[0]  = CLEAR_CODE;
				grp.width[0] = width_q;
				n            = GRP_CNT_BITS'(1);
				cur_n        = pix_code;
				run_n        = 1'b1;
			end else if (hit_ok) begin
				cur_n = hit_s2;
			end else begin
				grp.code[0]  = cur_q;
				grp.width[0] = width_q;
				n            = GRP_CNT_BITS'(1);
				wr_en        = 1'b1;
				nf_n         = nf_inc;
				if (width_q < MAX_WIDTH &&
				    {1'b0, nf_inc} >= ((CODE_BITS+1)'(1) << width_q))
					width_n = width_q + 1'b1;
				if (nf_inc >= DICT_LIMIT) begin
					grp.code[1]  = CLEAR_CODE;
					grp.width[1] = width_n;
					n            = GRP_CNT_BITS'(2);
					nf_n         = FIRST_FREE;
					width_n      = MIN_WIDTH;
				end
				cur_n = pix_code;
			end
			if (last_s2) begin
				grp.code[n]                       = cur_n;
				grp.width[n]                      = width_n;
				grp.code[n + GRP_CNT_BITS'(1)]    = CLEAR_CODE;
				grp.width[n + GRP_CNT_BITS'(1)]   = width_n;
				grp.code[n + GRP_CNT_BITS'(2)]    = END_CODE;
				grp.width[n + GRP_CNT_BITS'(2)]   = MIN_WIDTH;
				n       = n + GRP_CNT_BITS'(3);
				cur_n   = '0;
				run_n   = 1'b0;
				nf_n    = FIRST_FREE;
				width_n = MIN_WIDTH;
			end
			grp.count = n;
			grp.last  = last_s2;
		end
	end

	assign grp_valid = valid_s2 && (n != '0);

	// control and run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			cur_q    <= '0;
			run_q    <= 1'b0;
			width_q  <= MIN_WIDTH;
			nf_q     <= FIRST_FREE;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			cur_q    <= cur_n;
			run_q    <= run_n;
			width_q  <= width_n;
			nf_q     <= nf_n;
		end
	end

endmodule

// ----- rtl/glzw_packer.sv -----
// Code group FIFO and LSB-first bit packer with registered byte output.
module glzw_packer import glzw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      grp_valid,
	input  code_grp_t grp,
	output logic      grp_room,
	output logic      stream_valid,
	input  logic      stream_ready,
	output byte_out_t stream_data
);

	code_grp_t fifo_q [GRP_DEPTH];
	logic [GRP_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [GRP_LVL_BITS-1:0] lvl_q;
	logic [GRP_CNT_BITS-1:0] k_q, k_d;
	logic [ACC_BITS-1:0]     acc_q, acc_d;
	logic [ACC_N_BITS-1:0]   accn_q, accn_d;

	code_grp_t head;
	logic have, codes_done, load_ok, pop, emit, emit_end;
	logic [7:0] emit_byte;

	assign grp_room   = lvl_q <= GRP_ROOM_LVL;
	assign head       = fifo_q[rd_ptr_q];
	assign have       = lvl_q != '0;
	assign codes_done = k_q == head.count;
	assign load_ok    = !stream_valid || stream_ready;

	// one step a cycle unless stalled: byte out, else code in, else pad
	always_comb begin
		acc_d     = acc_q;
		accn_d    = accn_q;
		k_d       = k_q;
		pop       = 1'b0;
		emit      = 1'b0;
		emit_end  = 1'b0;
		emit_byte = acc_q[7:0];
		if (accn_q >= ACC_N_BITS'(8)) begin
			if (load_ok) begin
				emit     = 1'b1;
				emit_end = have && codes_done && head.last && accn_q == ACC_N_BITS'(8);
				acc_d    = acc_q >> 8;
				accn_d   = accn_q - ACC_N_BITS'(8);
				if (emit_end) begin
					pop = 1'b1;
					k_d = '0;
				end
			end
		end else if (have && !codes_done) begin
			acc_d  = acc_q | (ACC_BITS'(head.code[k_q]) << accn_q[2:0]);
			accn_d = accn_q + ACC_N_BITS'(head.width[k_q]);
			k_d    = k_q + 1'b1;
			if (k_d == head.count && !head.last) begin
				pop = 1'b1;
				k_d = '0;
			end
		end else if (have) begin
			if (accn_q == '0) begin
				pop = 1'b1;
				k_d = '0;
			end else if (load_ok) begin
				emit     = 1'b1;
				emit_end = 1'b1;
				acc_d    = '0;
				accn_d   = '0;
				pop      = 1'b1;
				k_d      = '0;
			end
		end
	end

	// FIFO storage
	always_ff @(posedge clk) begin
		if (grp_valid)
			fifo_q[wr_ptr_q] <= grp;
	end

	// output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			stream_data.code_byte    <= emit_byte;
			stream_data.end_of_image <= emit_end;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			lvl_q        <= '0;
			k_q          <= '0;
			acc_q        <= '0;
			accn_q       <= '0;
			stream_valid <= 1'b0;
		end else begin
			if (grp_valid)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			lvl_q  <= lvl_q + GRP_LVL_BITS'(grp_valid) - GRP_LVL_BITS'(pop);
			k_q    <= k_d;
			acc_q  <= acc_d;
			accn_q <= accn_d;
			if (emit)
				stream_valid <= 1'b1;
			else if (stream_ready)
				stream_valid <= 1'b0;
		end
	end

endmodule

// ----- rtl/glzw_checker.sv -----
// Port-level checks for the GIF LZW code packer, bound to the top level.
module glzw_checker import glzw_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      pixel_valid,
	input logic      pixel_ready,
	input logic      stream_valid,
	input logic      stream_ready,
	input byte_out_t stream_data
);

	// output held while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stream_valid && !stream_ready |=> stream_valid)
		else $error("output valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		stream_valid && !stream_ready |=> $stable(stream_data))
		else $error("output payload changed while stalled");

	// lookup pipeline drops pixel_ready after each accepted pixel
	a_pix_gap: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel_ready |=> !pixel_ready)
		else $error("pixel accepted in back-to-back cycles");

	// every image is several bytes long
	a_end_gap: assert property (@(posedge clk) disable iff (!arst_n)
		stream_valid && stream_ready && stream_data.end_of_image |=>
		!(stream_valid && stream_ready && stream_data.end_of_image))
		else $error("two end-of-image bytes in a row");

endmodule

bind gif_lzw_code_packer glzw_checker u_glzw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pixel_valid  (pixel_valid),
	.pixel_ready  (pixel_ready),
	.stream_valid (stream_valid),
	.stream_ready (stream_ready),
	.stream_data  (stream_data)
);

// ----- verif/tb_gif_lzw_code_packer.sv -----
// Testbench for the GIF LZW code packer: random pixel streams checked against a byte predictor.
module tb_gif_lzw_code_packer;
	import glzw_pkg::*;

	// Predicts packed LZW bytes for each accepted pixel and checks the output stream.
	class lzw_byte_board;
		logic [11:0] trie_next [int];
		logic [11:0] cur_code;
		bit          in_run;
		int unsigned width;
		logic [11:0] last_code;
		logic [7:0]  acc_byte;
		int unsigned acc_bits;
		byte_out_t   pending [$];
		int          errors;

		function void clear_state();
			trie_next.delete();
			width = SYM_BITS + 1;
			last_code = FIRST_FREE;
		endfunction

		function void init();
			clear_state();
			cur_code = '0;
			in_run = 0;
			acc_byte = '0;
			acc_bits = 0;
			pending.delete();
			errors = 0;
		endfunction

		function void push_bit(bit b);
			byte_out_t o;
			acc_byte[acc_bits] = b;
			acc_bits++;
			if (acc_bits == 8) begin
				o.code_byte = acc_byte;
				o.end_of_image = 1'b0;
				pending.push_back(o);
				acc_byte = '0;
				acc_bits = 0;
			end
		endfunction

		function void push_code(logic [11:0] c, int unsigned n);
			for (int i = 0; i < n; i++)
				push_bit(c[i]);
		endfunction

		// Note one accepted pixel and queue the bytes it completes.
		function void note_pixel(pix_in_t p);
			int key;
			if (!in_run) begin
				push_code(CLEAR_CODE, width);
				cur_code = {4'b0, p.pixel_index};
				in_run = 1;
			end else begin
				key = {cur_code, p.pixel_index};
				if (trie_next.exists(key)) begin
					cur_code = trie_next[key];
				end else begin
					push_code(cur_code, width);
					last_code = last_code + 1;
					trie_next[key] = last_code;
					if (width < 12 && last_code >= (1 << width))
						width++;
					if (last_code >= DICT_LIMIT) begin
						push_code(CLEAR_CODE, width);
						clear_state();
					end
					cur_code = {4'b0, p.pixel_index};
				end
			end
			if (p.last_pixel) begin
				push_code(cur_code, width);
				push_code(CLEAR_CODE, width);
				push_code(END_CODE, SYM_BITS + 1);
				while (acc_bits != 0)
					push_bit(1'b0);
				pending[$].end_of_image = 1'b1;
				clear_state();
				in_run = 0;
				cur_code = '0;
			end
		endfunction

		// Compare one received byte with the oldest expectation.
		function void check_byte(byte_out_t got);
			byte_out_t exp_b;
			if (pending.size() == 0) begin
				$error("unexpected byte %h", got.code_byte);
				errors++;
				return;
			end
			exp_b = pending.pop_front();
			if (got.code_byte !== exp_b.code_byte) begin
				$error("code_byte expected %h actual %h", exp_b.code_byte, got.code_byte);
				errors++;
			end
			if (got.end_of_image !== exp_b.end_of_image) begin
				$error("end_of_image expected %b actual %b",
					exp_b.end_of_image, got.end_of_image);
				errors++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      pixel_valid;
	logic      pixel_ready;
	pix_in_t   pixel_data;
	logic      stream_valid;
	logic      stream_ready;
	byte_out_t stream_data;

	lzw_byte_board board;
	int  send_idle_pct;
	int  recv_stall_pct;
	bit  hold_off;
	int  quiet_cycles;

	localparam int QUIET_LIMIT = 20000;

	gif_lzw_code_packer dut (
		.clk(clk), .arst_n(arst_n),
		.pixel_valid(pixel_valid), .pixel_ready(pixel_ready), .pixel_data(pixel_data),
		.stream_valid(stream_valid), .stream_ready(stream_ready), .stream_data(stream_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Offer one pixel, with random idle gaps before it; valid stays up between
	// back-to-back pixels and drops only while idling.
	task automatic send_pixel(input logic [7:0] idx, input bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel_data.pixel_index <= idx;
		pixel_data.last_pixel <= last;
		do
			@(posedge clk);
		while (!(pixel_valid && pixel_ready));
		board.note_pixel(pixel_data);
	endtask

	// One image of n pixels drawn from a palette of pal entries; a small palette makes runs repeat.
	task automatic send_image(input int n, input int pal);
		for (int i = 0; i < n; i++)
			send_pixel(8'($urandom_range(pal - 1)), i == n - 1);
	endtask

	task automatic drain();
		pixel_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Receiver: check accepted bytes and stall at random or during hold-off.
	always @(posedge clk) begin
		if (arst_n) begin
			if (stream_valid && stream_ready)
				board.check_byte(stream_data);
			stream_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog on cycles with no transaction.
	always @(posedge clk) begin
		if ((pixel_valid && pixel_ready) || (stream_valid && stream_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Long receiver hold-off while the sender keeps offering pixels.
	task automatic hold_receiver();
		hold_off <= 1'b1;
		repeat (300) @(posedge clk);
		hold_off <= 1'b0;
	endtask

	initial begin
		board = new();
		board.init();
		arst_n = 1'b0;
		pixel_valid = 1'b0;
		pixel_data = '0;
		stream_ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: one-pixel images (00, FF, AA, 55), a repeating run, an alternating image.
		send_pixel(8'h00, 1'b1);
		send_pixel(8'hFF, 1'b1);
		send_pixel(8'hAA, 1'b1);
		send_pixel(8'h55, 1'b1);
		for (int i = 0; i < 12; i++)
			send_pixel(8'h07, i == 11);
		send_pixel(8'h00, 1'b0);
		send_pixel(8'hFF, 1'b0);
		send_pixel(8'h00, 1'b0);
		send_pixel(8'hFF, 1'b1);
		drain();

		// Random phases with various idling and stalling, then a receiver hold-off.
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1) ? 75 : (ph == 3) ? 38 : 0;
			recv_stall_pct = (ph == 2) ? 75 : (ph == 3) ? 38 : 0;
			repeat (6) send_image($urandom_range(1, 20), (ph[0]) ? 256 : 4);
			if ($urandom_range(3) == 0)
				send_pixel(8'($urandom), 1'b0);
		end
		send_pixel(8'($urandom), 1'b1);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fork
			hold_receiver();
			send_image(40, 256);
		join
		drain();
		if (board.errors == 0 && board.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
